FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int PRIO_W    = 32;

    // operation code carried in the input tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares the incoming priority with its own,
// and takes the new item, the left neighbor's entry or the right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                 i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_occupied,
    input  spq_pkg::t_entry     i_left_entry,
    input  wire                 i_left_ins,
    input  spq_pkg::t_entry     i_right_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_ins
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // the new item belongs here or further left when this slot is free or
    // holds a priority not above the new one
    assign o_ins   = !i_occupied || (r_entry.prio <= i_ctrl.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq && o_ins) begin
            // shift right from the insertion point, drop the new item in at it
            n_entry = i_left_ins ? i_left_entry : i_ctrl.item;
        end else if (i_ctrl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded max-first priority queue held in a chain of sorted cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tuser
//  s_axis   in   [31:0] value_in [63:32] prio_in [0] func (0 enq, 1 deq)
//  m_axis   out  [31:0] value_out              [1:0] status
//
//  One operation per cycle while s_axis_tready is high: every cell compares
//  and moves in the same cycle; the result lands in a single output register.
//  s_axis_tready is high whenever the output register is empty or being read.
//  A stall on m_axis holds the result and stalls s_axis, nothing else.
//  Reset (i_rst_n low, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [63:0]  s_axis_tdata,   // [31:0] value_in, [63:32] prio_in
    input  wire          s_axis_tuser,   // [0] func
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [31:0] value_out
    output logic [1:0]   m_axis_tuser    // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    spq_pkg::t_status    r_status;
    spq_pkg::t_status    n_status;
    logic [31:0]         r_value;
    logic [31:0]         n_value;

    spq_pkg::t_cell_ctrl w_ctrl;
    spq_pkg::t_entry     w_entry [DEPTH];
    logic                w_ins   [DEPTH];
    logic                w_occ   [DEPTH];
    logic                w_accept;
    logic                w_full;
    logic                w_empty;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(DEPTH));
    assign w_empty       = (r_count == '0);

    assign w_ctrl.enq        = w_accept && (s_axis_tuser == spq_pkg::OP_ENQ) && !w_full;
    assign w_ctrl.deq        = w_accept && (s_axis_tuser == spq_pkg::OP_DEQ) && !w_empty;
    assign w_ctrl.item.value = s_axis_tdata[31:0];
    assign w_ctrl.item.prio  = s_axis_tdata[63:32];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_ins;

        assign w_occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_ins = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (w_occ[g]),
            .i_left_entry  (w_left),
            .i_left_ins    (w_left_ins),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_ins         (w_ins[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value     = r_value;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_value     = '0;
            n_status    = spq_pkg::ST_OK;
            if (s_axis_tuser == spq_pkg::OP_ENQ) begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_value = w_entry[0].value;
                    n_count = r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_value;
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire

FILE: hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the queue core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,
    input  wire  [1:0]  m_axis_tuser
);

    // every accepted transaction shows its result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == spq_pkg::ST_OK) ||
                          (m_axis_tuser == spq_pkg::ST_EMPTY) ||
                          (m_axis_tuser == spq_pkg::ST_FULL))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != spq_pkg::ST_OK) |-> m_axis_tdata == '0)
        else $error("nonzero value on error status");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
